/* sv/fpr_pkg.sv */
// shared types, constants and helpers of the framed packet receiver
package fpr_pkg;

    localparam int SLOTS         = 4;
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int FILL_W        = 3;
    localparam int PAYLOAD_BYTES = 64;
    localparam int MEM_DEPTH     = SLOTS * PAYLOAD_BYTES;
    localparam int MEM_AW        = $clog2(MEM_DEPTH);
    localparam int POS_W         = 7;
    localparam int IDX_W         = 6;
    localparam int QUEUE_DEPTH   = 2;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_POP  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LEN_ERR  = 3'd1;
    localparam logic [2:0] ST_TOK_ERR  = 3'd2;
    localparam logic [2:0] ST_VER_ERR  = 3'd3;
    localparam logic [2:0] ST_CSUM_ERR = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_MASK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_MASK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_BC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BC_NODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOKEN       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION     = 3'd6;

    localparam logic [7:0] SYNC_B0 = 8'h55;
    localparam logic [7:0] SYNC_B1 = 8'h4E;
    localparam logic [7:0] SYNC_B2 = 8'h45;
    localparam logic [7:0] SYNC_B3 = 8'h52;

    localparam logic [3:0]       RST_BC_NODE     = 4'd15;
    localparam logic [POS_W-1:0] RST_MAX_PAYLOAD = 7'd64;
    localparam logic [7:0]       RST_TOKEN       = 8'd58;
    localparam logic [7:0]       RST_VERSION     = 8'd2;

    typedef struct packed {
        logic [7:0]       ver;
        logic [3:0]       src;
        logic [3:0]       dst;
        logic [7:0]       cmd;
        logic [POS_W-1:0] len;
        logic [7:0]       transport;
    } hdr_t;

    typedef struct packed {
        logic [2:0]        status;
        logic              committed;
        logic [FILL_W-1:0] count;
        logic              pay_we;
        logic [MEM_AW-1:0] pay_addr;
        logic [7:0]        pay_data;
        logic              hdr_we;
        logic [SLOT_W-1:0] hdr_slot;
        hdr_t              hdr;
        logic              rep_valid;
        logic [SLOT_W-1:0] rep_slot;
        logic [MEM_AW-1:0] rd_addr;
        logic [IDX_W-1:0]  rd_idx;
    } op_t;

    function automatic logic [MEM_AW-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [POS_W-1:0] off);
        slot_addr = MEM_AW'(slot) * MEM_AW'(PAYLOAD_BYTES) + MEM_AW'(off);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
        slot_inc = (slot == SLOT_W'(SLOTS - 1)) ? '0 : slot + 1'b1;
    endfunction

endpackage

/* sv/fpr_front.sv */
// front end: frame parser, filters and queue pointers, emits one op per item
module fpr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fpr_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [7:0]                    data_byte,
    input  logic [7:0]                    link_id,
    input  logic [7:0]                    transport_max_payload,
    input  logic [fpr_pkg::IDX_W-1:0]     read_index,
    output fpr_pkg::op_t                  op,
    output logic                          op_push
);
    import fpr_pkg::*;

    typedef enum logic [3:0] {
        PH_H0, PH_H1, PH_H2, PH_H3, PH_LEN, PH_TOKEN, PH_VER,
        PH_ROUTE, PH_CMD, PH_PAYLOAD, PH_CHK
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        csum_reg, csum_next;
    logic [POS_W-1:0]  exp_len_reg, exp_len_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        route_reg, route_next;
    logic [7:0]        opcode_reg, opcode_next;
    logic              drop_reg, drop_next;
    logic [7:0]        ver_reg, ver_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic [15:0]       src_mask_reg;
    logic [15:0]       dst_mask_reg;
    logic              accept_bc_reg;
    logic [3:0]        bc_node_reg;
    logic [POS_W-1:0]  max_payload_reg;
    logic [7:0]        token_reg;
    logic [7:0]        version_reg;

    logic              fire;
    logic              clear;
    logic [POS_W-1:0]  lim;
    logic [3:0]        src;
    logic [3:0]        dst;
    logic              dst_ok;
    logic [POS_W-1:0]  pos_inc;

    assign fire    = in_valid && in_ready;
    assign op_push = fire;
    assign src     = route_reg[7:4];
    assign dst     = route_reg[3:0];
    assign dst_ok  = (dst == bc_node_reg) ? accept_bc_reg : dst_mask_reg[dst];
    assign lim     = (max_payload_reg < POS_W'(PAYLOAD_BYTES)) ? max_payload_reg
                                                               : POS_W'(PAYLOAD_BYTES);
    assign pos_inc = pos_reg + 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        csum_next    = csum_reg;
        exp_len_next = exp_len_reg;
        pos_next     = pos_reg;
        route_next   = route_reg;
        opcode_next  = opcode_reg;
        drop_next    = drop_reg;
        ver_next     = ver_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        clear        = 1'b0;
        op           = '0;
        op.status    = ST_OK;

        if (fire)
        begin
            case (cmd)
                CMD_PUSH:
                begin
                    case (phase_reg)
                        PH_H0:
                        begin
                            if (data_byte == SYNC_B0)
                            begin
                                csum_next  = data_byte;
                                phase_next = PH_H1;
                            end
                        end
                        PH_H1, PH_H2, PH_H3:
                        begin
                            if ((phase_reg == PH_H1 && data_byte == SYNC_B1) ||
                                (phase_reg == PH_H2 && data_byte == SYNC_B2) ||
                                (phase_reg == PH_H3 && data_byte == SYNC_B3))
                            begin
                                csum_next  = csum_reg ^ data_byte;
                                phase_next = (phase_reg == PH_H1) ? PH_H2 :
                                             (phase_reg == PH_H2) ? PH_H3 : PH_LEN;
                            end
                            else if (data_byte == SYNC_B0)
                            begin
                                csum_next  = data_byte;
                                phase_next = PH_H1;
                            end
                            else
                            begin
                                csum_next  = '0;
                                phase_next = PH_H0;
                            end
                        end
                        PH_LEN:
                        begin
                            if (data_byte > 8'(lim) || data_byte > transport_max_payload)
                            begin
                                clear     = 1'b1;
                                op.status = ST_LEN_ERR;
                            end
                            else
                            begin
                                exp_len_next = data_byte[POS_W-1:0];
                                csum_next    = csum_reg ^ data_byte;
                                if (fill_reg >= FILL_W'(SLOTS))
                                begin
                                    drop_next = 1'b1;
                                end
                                pos_next   = '0;
                                phase_next = PH_TOKEN;
                            end
                        end
                        PH_TOKEN:
                        begin
                            if (data_byte != token_reg)
                            begin
                                clear     = 1'b1;
                                op.status = ST_TOK_ERR;
                            end
                            else
                            begin
                                csum_next  = csum_reg ^ data_byte;
                                phase_next = PH_VER;
                            end
                        end
                        PH_VER:
                        begin
                            if (data_byte != version_reg)
                            begin
                                clear     = 1'b1;
                                op.status = ST_VER_ERR;
                            end
                            else
                            begin
                                ver_next   = data_byte;
                                csum_next  = csum_reg ^ data_byte;
                                phase_next = PH_ROUTE;
                            end
                        end
                        PH_ROUTE:
                        begin
                            route_next = data_byte;
                            csum_next  = csum_reg ^ data_byte;
                            phase_next = PH_CMD;
                        end
                        PH_CMD:
                        begin
                            opcode_next = data_byte;
                            csum_next   = csum_reg ^ data_byte;
                            phase_next  = (exp_len_reg == '0) ? PH_CHK : PH_PAYLOAD;
                        end
                        PH_PAYLOAD:
                        begin
                            if (!drop_reg && pos_reg < POS_W'(PAYLOAD_BYTES))
                            begin
                                op.pay_we   = 1'b1;
                                op.pay_addr = slot_addr(head_reg, pos_reg);
                                op.pay_data = data_byte;
                            end
                            pos_next  = pos_inc;
                            csum_next = csum_reg ^ data_byte;
                            if (pos_inc >= exp_len_reg)
                            begin
                                phase_next = PH_CHK;
                            end
                        end
                        PH_CHK:
                        begin
                            clear = 1'b1;
                            if (data_byte != csum_reg)
                            begin
                                op.status = ST_CSUM_ERR;
                            end
                            else if (!drop_reg && src_mask_reg[src] && dst_ok &&
                                     fill_reg < FILL_W'(SLOTS))
                            begin
                                op.hdr_we        = 1'b1;
                                op.hdr_slot      = head_reg;
                                op.hdr.ver       = ver_reg;
                                op.hdr.src       = src;
                                op.hdr.dst       = dst;
                                op.hdr.cmd       = opcode_reg;
                                op.hdr.len       = exp_len_reg;
                                op.hdr.transport = link_id;
                                op.committed     = 1'b1;
                                head_next        = slot_inc(head_reg);
                                fill_next        = fill_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            clear = 1'b1;
                        end
                    endcase
                    op.rep_valid = (fill_next != '0);
                    op.rep_slot  = tail_reg;
                end
                default:
                begin
                    if (fill_reg == '0)
                    begin
                        op.status = ST_EMPTY;
                    end
                    else
                    begin
                        op.rep_valid = 1'b1;
                        op.rep_slot  = tail_reg;
                        if (cmd == CMD_POP)
                        begin
                            tail_next = slot_inc(tail_reg);
                            fill_next = fill_reg - 1'b1;
                        end
                    end
                end
            endcase

            if (clear)
            begin
                phase_next   = PH_H0;
                csum_next    = '0;
                exp_len_next = '0;
                pos_next     = '0;
                route_next   = '0;
                opcode_next  = '0;
                drop_next    = 1'b0;
                ver_next     = '0;
            end
        end

        op.count   = fill_next;
        op.rd_addr = slot_addr(op.rep_slot, POS_W'(read_index));
        op.rd_idx  = read_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_H0;
            csum_reg    <= '0;
            exp_len_reg <= '0;
            pos_reg     <= '0;
            route_reg   <= '0;
            opcode_reg  <= '0;
            drop_reg    <= 1'b0;
            ver_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            csum_reg    <= csum_next;
            exp_len_reg <= exp_len_next;
            pos_reg     <= pos_next;
            route_reg   <= route_next;
            opcode_reg  <= opcode_next;
            drop_reg    <= drop_next;
            ver_reg     <= ver_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_mask_reg    <= '1;
            dst_mask_reg    <= '1;
            accept_bc_reg   <= 1'b1;
            bc_node_reg     <= RST_BC_NODE;
            max_payload_reg <= RST_MAX_PAYLOAD;
            token_reg       <= RST_TOKEN;
            version_reg     <= RST_VERSION;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_MASK:    src_mask_reg    <= cfg_data;
                REG_DST_MASK:    dst_mask_reg    <= cfg_data;
                REG_ACCEPT_BC:   accept_bc_reg   <= cfg_data[0];
                REG_BC_NODE:     bc_node_reg     <= cfg_data[3:0];
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data[POS_W-1:0];
                REG_TOKEN:       token_reg       <= cfg_data[7:0];
                REG_VERSION:     version_reg     <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(SLOTS))
        else $error("queue fill above slot count");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == '0 |-> head_reg == tail_reg)
        else $error("empty queue with diverged pointers");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && op.status == ST_EMPTY) |-> fill_reg == '0)
        else $error("empty status with packets queued");

    a_commit_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && op.committed) |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("commit did not grow the queue");

endmodule

/* sv/fpr_fifo.sv */
// short op queue between parser front end and store back end
module fpr_fifo #(
    parameter int DEPTH = fpr_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  fpr_pkg::op_t push_data,
    output logic         ready,
    output logic         out_valid,
    output fpr_pkg::op_t out_data,
    input  logic         pop
);
    import fpr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign ready     = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && ready;
    assign do_pop    = pop && out_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/fpr_back.sv */
// back end: slot header and payload stores, result register
module fpr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    input  fpr_pkg::op_t                  op,
    output logic                          op_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fpr_pkg::M_TDATA_W-1:0] m_tdata
);
    import fpr_pkg::*;

    hdr_t              hdr_mem_reg [SLOTS];
    logic [7:0]        pay_mem [MEM_DEPTH];

    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic              committed_reg;
    logic [FILL_W-1:0] count_reg;
    hdr_t              rep_hdr_reg;
    logic [7:0]        rd_data_reg;
    logic              show_hdr_reg;
    logic              show_byte_reg;

    logic              take;
    hdr_t              rep_hdr;
    hdr_t              hdr_out;
    logic [7:0]        byte_out;

    assign take    = op_valid && (!out_valid_reg || m_tready);
    assign op_pop  = take;
    assign rep_hdr = (op.hdr_we && op.hdr_slot == op.rep_slot) ? op.hdr
                                                               : hdr_mem_reg[op.rep_slot];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg    <= op.status;
            committed_reg <= op.committed;
            count_reg     <= op.count;
            rep_hdr_reg   <= rep_hdr;
            show_hdr_reg  <= op.rep_valid;
            show_byte_reg <= op.rep_valid && (POS_W'(op.rd_idx) < rep_hdr.len);
            if (op.hdr_we)
            begin
                hdr_mem_reg[op.hdr_slot] <= op.hdr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && op.pay_we)
        begin
            pay_mem[op.pay_addr] <= op.pay_data;
        end
        if (take)
        begin
            rd_data_reg <= pay_mem[op.rd_addr];
        end
    end

    assign hdr_out  = show_hdr_reg ? rep_hdr_reg : '0;
    assign byte_out = show_byte_reg ? rd_data_reg : '0;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, byte_out, hdr_out.transport, hdr_out.len, hdr_out.cmd,
                       hdr_out.dst, hdr_out.src, hdr_out.ver, count_reg, committed_reg,
                       status_reg};

endmodule

/* sv/framed_packet_receiver_queue_core.sv */
// top level of the framed packet receiver with its packet queue
//
// s_* carries one item per handshake: a received byte to push (s_tuser = push)
// or a read or pop of the oldest queued packet. m_* returns exactly one result
// item per accepted item, in order, with status, commit flag, queue count and
// the header and one payload byte of the oldest packet.
// cfg_we/cfg_index/cfg_data write the filter and limit registers;
// write them only while no item is in flight.
// The block takes one item per cycle while s_tready is high. From acceptance an item
// passes through the two-entry op queue after the parser, then through the store
// read into the result register that drives m_tvalid. The payload store has
// one write and one read port, used once per item.
// When m_tready is low the result register holds, the op queue fills and
// s_tready drops once it holds two items; nothing is lost.
// Reset clears the parser, queue pointers and configuration to defaults;
// the slot stores are not cleared, and their unwritten contents never reach m_tdata.
module framed_packet_receiver_queue_core #(
    parameter int QUEUE_DEPTH = fpr_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fpr_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // data_byte, link id, transport_max_payload, read_index, zero pad
    input  logic [fpr_pkg::S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, frame_committed, queue_count, head_version, head_source,
    // head_destination, head_command, head_length, head_transport,
    // payload_byte, zero pad
    output logic [fpr_pkg::M_TDATA_W-1:0] m_tdata
);
    import fpr_pkg::*;

    op_t  front_op;
    logic front_push;
    op_t  back_op;
    logic back_valid;
    logic back_pop;

    fpr_front u_front (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .in_valid              (s_tvalid),
        .in_ready              (s_tready),
        .cmd                   (s_tuser),
        .data_byte             (s_tdata[7:0]),
        .link_id               (s_tdata[15:8]),
        .transport_max_payload (s_tdata[23:16]),
        .read_index            (s_tdata[24 +: IDX_W]),
        .op                    (front_op),
        .op_push               (front_push)
    );

    fpr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_op),
        .ready     (s_tready),
        .out_valid (back_valid),
        .out_data  (back_op),
        .pop       (back_pop)
    );

    fpr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (back_valid),
        .op       (back_op),
        .op_pop   (back_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* bench/tb.sv */
// testbench for the framed packet receiver: frame parsing, filters, packet queue and readout
module tb;
    import fpr_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    // result item as it sits in m_tdata, lowest field last
    typedef struct packed {
        logic [1:0]        pad;
        logic [7:0]        payload;
        logic [7:0]        transport;
        logic [POS_W-1:0]  len;
        logic [7:0]        cmd;
        logic [3:0]        dst;
        logic [3:0]        src;
        logic [7:0]        ver;
        logic [FILL_W-1:0] count;
        logic              committed;
        logic [2:0]        status;
    } reply_t;

    typedef enum logic [3:0] {
        SEEK_U, SEEK_N, SEEK_E, SEEK_R, GET_LEN, GET_TOKEN, GET_VER,
        GET_ROUTE, GET_OPCODE, GET_PAYLOAD, GET_CHECK
    } parse_state_t;

    typedef enum {
        GOOD_FRAME, BAD_SYNC, OVER_LIMIT, OVER_LINK_LIMIT, BAD_TOKEN, BAD_VERSION, BAD_CHECKSUM
    } frame_kind_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // register mirror
    logic [15:0]      src_mask;
    logic [15:0]      dst_mask;
    logic             bc_accept;
    logic [3:0]       bc_node;
    logic [POS_W-1:0] max_pay;
    logic [7:0]       token_cfg;
    logic [7:0]       version_cfg;

    // receiver state mirror
    parse_state_t      rx_state;
    logic [7:0]        rx_csum;
    logic [7:0]        rx_len;
    logic [POS_W-1:0]  rx_pos;
    logic [7:0]        rx_route;
    logic [7:0]        rx_opcode;
    logic              rx_drop;
    logic [7:0]        rx_ver;
    hdr_t              slot_hdr [SLOTS];
    logic [7:0]        slot_payload [MEM_DEPTH];
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic [FILL_W-1:0] fill;

    reply_t pending_replies[$];
    int     mismatches;
    int     items_sent;
    int     send_idle_pct;
    int     recv_stall_pct;

    framed_packet_receiver_queue_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_frame();
        rx_state  = SEEK_U;
        rx_csum   = 8'h00;
        rx_len    = 8'h00;
        rx_pos    = '0;
        rx_route  = 8'h00;
        rx_opcode = 8'h00;
        rx_drop   = 1'b0;
        rx_ver    = 8'h00;
    endfunction

    // header byte did not match: restart on a sync byte, else hunt again
    function automatic void resync(input logic [7:0] data);
        if (data == SYNC_B0)
        begin
            rx_state = SEEK_N;
            rx_csum  = data;
        end
        else
        begin
            rx_state = SEEK_U;
            rx_csum  = 8'h00;
        end
    endfunction

    function automatic void load_head(input logic [IDX_W-1:0] idx, inout reply_t r);
        hdr_t h;
        h = slot_hdr[rd_slot];
        r.ver       = h.ver;
        r.src       = h.src;
        r.dst       = h.dst;
        r.cmd       = h.cmd;
        r.len       = h.len;
        r.transport = h.transport;
        r.payload   = (idx < h.len) ?
                      slot_payload[int'(rd_slot) * PAYLOAD_BYTES + int'(idx)] : 8'h00;
    endfunction

    task automatic receiver_step(input logic [1:0] cmd, input logic [7:0] data,
                                 input logic [7:0] tid, input logic [7:0] tmax,
                                 input logic [IDX_W-1:0] idx, output reply_t r);
        logic [7:0] lim;
        logic [3:0] src_node;
        logic [3:0] dst_node;
        logic       dst_pass;
        r = '0;
        r.status = ST_OK;
        if (cmd == CMD_PUSH)
        begin
            case (rx_state)
                SEEK_U:
                    if (data == SYNC_B0)
                    begin
                        rx_csum  = data;
                        rx_state = SEEK_N;
                    end
                SEEK_N:
                    if (data == SYNC_B1)
                    begin
                        rx_csum ^= data;
                        rx_state = SEEK_E;
                    end
                    else
                        resync(data);
                SEEK_E:
                    if (data == SYNC_B2)
                    begin
                        rx_csum ^= data;
                        rx_state = SEEK_R;
                    end
                    else
                        resync(data);
                SEEK_R:
                    if (data == SYNC_B3)
                    begin
                        rx_csum ^= data;
                        rx_state = GET_LEN;
                    end
                    else
                        resync(data);
                GET_LEN:
                begin
                    lim = (max_pay < PAYLOAD_BYTES) ? 8'(max_pay) : 8'(PAYLOAD_BYTES);
                    if (data > lim || data > tmax)
                    begin
                        clear_frame();
                        r.status = ST_LEN_ERR;
                    end
                    else
                    begin
                        rx_len   = data;
                        rx_csum ^= data;
                        if (fill >= SLOTS)
                            rx_drop = 1'b1;
                        rx_pos   = '0;
                        rx_state = GET_TOKEN;
                    end
                end
                GET_TOKEN:
                    if (data != token_cfg)
                    begin
                        clear_frame();
                        r.status = ST_TOK_ERR;
                    end
                    else
                    begin
                        rx_csum ^= data;
                        rx_state = GET_VER;
                    end
                GET_VER:
                    if (data != version_cfg)
                    begin
                        clear_frame();
                        r.status = ST_VER_ERR;
                    end
                    else
                    begin
                        rx_ver   = data;
                        rx_csum ^= data;
                        rx_state = GET_ROUTE;
                    end
                GET_ROUTE:
                begin
                    rx_route = data;
                    rx_csum ^= data;
                    rx_state = GET_OPCODE;
                end
                GET_OPCODE:
                begin
                    rx_opcode = data;
                    rx_csum  ^= data;
                    rx_state  = (rx_len == 8'h00) ? GET_CHECK : GET_PAYLOAD;
                end
                GET_PAYLOAD:
                begin
                    if (!rx_drop && rx_pos < PAYLOAD_BYTES)
                        slot_payload[int'(wr_slot) * PAYLOAD_BYTES + int'(rx_pos)] = data;
                    rx_pos   = rx_pos + 1'b1;
                    rx_csum ^= data;
                    if (rx_pos >= rx_len)
                        rx_state = GET_CHECK;
                end
                GET_CHECK:
                begin
                    src_node = rx_route[7:4];
                    dst_node = rx_route[3:0];
                    dst_pass = (dst_node == bc_node) ? bc_accept : dst_mask[dst_node];
                    if (data != rx_csum)
                        r.status = ST_CSUM_ERR;
                    else if (!rx_drop && src_mask[src_node] && dst_pass && fill < SLOTS)
                    begin
                        slot_hdr[wr_slot].ver       = rx_ver;
                        slot_hdr[wr_slot].src       = src_node;
                        slot_hdr[wr_slot].dst       = dst_node;
                        slot_hdr[wr_slot].cmd       = rx_opcode;
                        slot_hdr[wr_slot].len       = POS_W'(rx_len);
                        slot_hdr[wr_slot].transport = tid;
                        wr_slot     = SLOT_W'((int'(wr_slot) + 1) % SLOTS);
                        fill        = fill + 1'b1;
                        r.committed = 1'b1;
                    end
                    clear_frame();
                end
                default:
                    clear_frame();
            endcase
            if (fill != 0)
                load_head(idx, r);
        end
        else if (fill == 0)
            r.status = ST_EMPTY;
        else
        begin
            load_head(idx, r);
            if (cmd == CMD_POP)
            begin
                rd_slot = SLOT_W'((int'(rd_slot) + 1) % SLOTS);
                fill    = fill - 1'b1;
            end
        end
        r.count = fill;
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                             input logic [7:0] tid, input logic [7:0] tmax,
                             input logic [IDX_W-1:0] idx);
        reply_t r;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, idx, tmax, tid, data};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        receiver_step(cmd, data, tid, tmax, idx, r);
        pending_replies.push_back(r);
        items_sent++;
    endtask

    task automatic query(input logic [1:0] cmd, input logic [IDX_W-1:0] idx);
        send_item(cmd, 8'($urandom), 8'($urandom), 8'($urandom), idx);
    endtask

    function automatic logic [1:0] pick_query();
        if ($urandom_range(1) == 1)
            return CMD_POP;
        return ($urandom_range(3) == 0) ? CMD_SPARE : CMD_READ;
    endfunction

    // len and route below zero are drawn at random
    task automatic send_frame(input frame_kind_t kind, input int len, input int route,
                              input int mix_pct, input int pop_at);
        logic [7:0] frame_bytes[$];
        logic [7:0] csum;
        logic [7:0] tmax;
        logic [7:0] bad;
        int         lim;
        lim = (max_pay < PAYLOAD_BYTES) ? int'(max_pay) : PAYLOAD_BYTES;
        if (len < 0)
            len = ($urandom_range(9) == 0) ? $urandom_range(lim) :
                  $urandom_range(lim < 8 ? lim : 8);
        if (route < 0)
            route = $urandom_range(255);
        if (kind == OVER_LINK_LIMIT && lim > 0)
            len = $urandom_range(lim, 1);
        else if (kind == OVER_LINK_LIMIT || kind == OVER_LIMIT)
            len = $urandom_range(255, lim + 1);
        tmax = (kind == OVER_LINK_LIMIT && lim > 0) ? 8'($urandom_range(len - 1)) :
               8'($urandom_range(255, len));
        frame_bytes.push_back(SYNC_B0);
        frame_bytes.push_back(SYNC_B1);
        if (kind == BAD_SYNC)
        begin
            bad = ($urandom_range(1) == 1) ? SYNC_B0 : 8'($urandom);
            if (bad == SYNC_B2)
                bad = SYNC_B3;
            frame_bytes.push_back(bad);
        end
        else
        begin
            frame_bytes.push_back(SYNC_B2);
            frame_bytes.push_back(SYNC_B3);
            frame_bytes.push_back(8'(len));
            if (kind != OVER_LIMIT && kind != OVER_LINK_LIMIT)
            begin
                frame_bytes.push_back((kind == BAD_TOKEN) ?
                                      token_cfg ^ 8'($urandom_range(255, 1)) : token_cfg);
                if (kind != BAD_TOKEN)
                begin
                    frame_bytes.push_back((kind == BAD_VERSION) ?
                                          version_cfg ^ 8'($urandom_range(255, 1)) :
                                          version_cfg);
                    if (kind != BAD_VERSION)
                    begin
                        frame_bytes.push_back(8'(route));
                        frame_bytes.push_back(8'($urandom));
                        repeat (len)
                            frame_bytes.push_back(8'($urandom));
                        csum = 8'h00;
                        foreach (frame_bytes[i])
                            csum ^= frame_bytes[i];
                        if (kind == BAD_CHECKSUM)
                            csum ^= 8'($urandom_range(255, 1));
                        frame_bytes.push_back(csum);
                    end
                end
            end
        end
        foreach (frame_bytes[i])
        begin
            if (i == pop_at)
                query(CMD_POP, IDX_W'($urandom));
            else if ($urandom_range(99) < mix_pct)
                query(pick_query(), IDX_W'($urandom));
            send_item(CMD_PUSH, frame_bytes[i], 8'($urandom), tmax, IDX_W'($urandom));
        end
    endtask

    task automatic flush_queue();
        while (fill != 0)
            query(CMD_POP, IDX_W'($urandom));
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SRC_MASK:    src_mask    = value;
            REG_DST_MASK:    dst_mask    = value;
            REG_ACCEPT_BC:   bc_accept   = value[0];
            REG_BC_NODE:     bc_node     = value[3:0];
            REG_MAX_PAYLOAD: max_pay     = value[POS_W-1:0];
            REG_TOKEN:       token_cfg   = value[7:0];
            REG_VERSION:     version_cfg = value[7:0];
            default:         ;
        endcase
    endtask

    task automatic test_empty_queue();
        query(CMD_READ, '0);
        query(CMD_POP, '1);
        query(CMD_SPARE, '0);
        send_item(CMD_PUSH, 8'h00, 8'h00, 8'h00, '0);
        send_item(CMD_PUSH, 8'hFF, 8'hFF, 8'hFF, '1);
    endtask

    task automatic test_good_frames();
        send_frame(GOOD_FRAME, 0, 8'h00, 0, -1);
        send_frame(GOOD_FRAME, PAYLOAD_BYTES, 8'hFF, 0, -1);
        query(CMD_READ, '0);
        query(CMD_POP, IDX_W'(1));
        query(CMD_READ, '0);
        query(CMD_SPARE, '1);
        query(CMD_POP, IDX_W'(40));
        query(CMD_READ, '0);
    endtask

    task automatic test_header_resync();
        send_item(CMD_PUSH, SYNC_B0, 8'h01, 8'h40, '0);
        send_item(CMD_PUSH, SYNC_B1, 8'h02, 8'h40, '0);
        send_item(CMD_PUSH, SYNC_B2, 8'h03, 8'h40, '0);
        send_item(CMD_PUSH, SYNC_B0, 8'h04, 8'h40, '0);
        send_item(CMD_PUSH, 8'hA5, 8'h05, 8'h40, '0);
        send_frame(BAD_SYNC, -1, -1, 0, -1);
        send_frame(GOOD_FRAME, 5, 8'h21, 30, -1);
        flush_queue();
    endtask

    task automatic test_frame_errors();
        send_frame(OVER_LIMIT, -1, -1, 0, -1);
        send_frame(OVER_LINK_LIMIT, -1, -1, 0, -1);
        send_frame(BAD_TOKEN, -1, -1, 0, -1);
        send_frame(BAD_VERSION, -1, -1, 0, -1);
        send_frame(BAD_CHECKSUM, 3, 8'h12, 0, -1);
        send_frame(GOOD_FRAME, 2, 8'h12, 0, -1);
        flush_queue();
    endtask

    task automatic test_queue_full();
        repeat (SLOTS)
            send_frame(GOOD_FRAME, -1, 8'h12, 0, -1);
        // no free slot: dropped
        send_frame(GOOD_FRAME, 2, 8'h12, 0, -1);
        query(CMD_POP, '0);
        send_frame(GOOD_FRAME, 1, 8'h21, 0, -1);
        // full at the length byte, a slot frees up mid-frame: still dropped
        send_frame(GOOD_FRAME, 3, 8'h12, 0, 6);
        send_frame(GOOD_FRAME, 1, 8'h34, 0, -1);
        flush_queue();
    endtask

    task automatic test_filters_and_limits();
        drain();
        write_reg(REG_SRC_MASK, 16'h0000);
        send_frame(GOOD_FRAME, 1, 8'h50, 0, -1);
        drain();
        write_reg(REG_SRC_MASK, 16'hFFFF);
        write_reg(REG_DST_MASK, 16'h0000);
        send_frame(GOOD_FRAME, 1, 8'h3F, 0, -1);
        send_frame(GOOD_FRAME, 1, 8'h33, 0, -1);
        drain();
        write_reg(REG_DST_MASK, 16'hFFFF);
        write_reg(REG_ACCEPT_BC, 16'h0000);
        write_reg(REG_BC_NODE, 16'h0004);
        send_frame(GOOD_FRAME, 1, 8'h74, 0, -1);
        send_frame(GOOD_FRAME, 1, 8'h7F, 0, -1);
        flush_queue();
        drain();
        write_reg(REG_ACCEPT_BC, 16'h0001);
        write_reg(REG_BC_NODE, 16'h0000);
        write_reg(REG_MAX_PAYLOAD, 16'h0000);
        send_frame(GOOD_FRAME, 0, 8'h10, 0, -1);
        send_frame(OVER_LIMIT, -1, -1, 0, -1);
        drain();
        write_reg(REG_TOKEN, 16'h0000);
        write_reg(REG_VERSION, 16'h00FF);
        write_reg(REG_MAX_PAYLOAD, CFG_W'(PAYLOAD_BYTES));
        send_frame(GOOD_FRAME, 2, 8'h56, 0, -1);
        drain();
        write_reg(REG_TOKEN, 16'h00FF);
        write_reg(REG_VERSION, 16'h0000);
        send_frame(GOOD_FRAME, 2, 8'h65, 0, -1);
        send_frame(BAD_TOKEN, -1, -1, 0, -1);
        send_frame(BAD_VERSION, -1, -1, 0, -1);
        flush_queue();
    endtask

    task automatic test_random_traffic();
        int idle_send[4] = '{0, 82, 0, 23};
        int idle_recv[4] = '{0, 0, 82, 23};
        int goal;
        int pick;
        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_reg(REG_SRC_MASK, CFG_W'($urandom | $urandom));
            write_reg(REG_DST_MASK, CFG_W'($urandom | $urandom));
            write_reg(REG_ACCEPT_BC, CFG_W'($urandom_range(1)));
            write_reg(REG_BC_NODE, CFG_W'($urandom_range(15)));
            write_reg(REG_MAX_PAYLOAD,
                      CFG_W'((p == 0) ? PAYLOAD_BYTES : $urandom_range(PAYLOAD_BYTES, 1)));
            write_reg(REG_TOKEN, CFG_W'($urandom_range(255)));
            write_reg(REG_VERSION, CFG_W'($urandom_range(255)));
            send_idle_pct  = idle_send[p];
            recv_stall_pct = idle_recv[p];
            goal = items_sent + 285;
            while (items_sent < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                    send_frame(GOOD_FRAME, -1, -1, 5, -1);
                else if (pick < 62)
                    send_frame(frame_kind_t'($urandom_range(BAD_CHECKSUM, BAD_SYNC)),
                               -1, -1, 5, -1);
                else if (pick < 92)
                    query(pick_query(), IDX_W'($urandom));
                else
                    send_item(CMD_PUSH, 8'($urandom), 8'($urandom), 8'($urandom),
                              IDX_W'($urandom));
            end
        end
    endtask

    function automatic void flag_reply(input string what, input reply_t want, input reply_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s: expected st=%0d c=%0d n=%0d v=%h s=%h d=%h op=%h l=%0d t=%h p=%h",
                     what, want.status, want.committed, want.count, want.ver, want.src,
                     want.dst, want.cmd, want.len, want.transport, want.payload);
            $display("  actual st=%0d c=%0d n=%0d v=%h s=%h d=%h op=%h l=%0d t=%h p=%h",
                     got.status, got.committed, got.count, got.ver, got.src,
                     got.dst, got.cmd, got.len, got.transport, got.payload);
        end
    endfunction

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_replies
        reply_t got;
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = reply_t'(m_tdata);
            if (pending_replies.size() == 0)
                flag_reply("unexpected item", '0, got);
            else
            begin
                want = pending_replies.pop_front();
                if (got.status !== want.status || got.committed !== want.committed ||
                    got.count !== want.count || got.ver !== want.ver ||
                    got.src !== want.src || got.dst !== want.dst || got.cmd !== want.cmd ||
                    got.len !== want.len || got.transport !== want.transport ||
                    got.payload !== want.payload)
                    flag_reply("mismatch", want, got);
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_PUSH;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        items_sent     = 0;
        src_mask       = 16'hFFFF;
        dst_mask       = 16'hFFFF;
        bc_accept      = 1'b1;
        bc_node        = RST_BC_NODE;
        max_pay        = RST_MAX_PAYLOAD;
        token_cfg      = RST_TOKEN;
        version_cfg    = RST_VERSION;
        wr_slot        = '0;
        rd_slot        = '0;
        fill           = '0;
        clear_frame();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_queue();
        test_good_frames();
        test_header_resync();
        test_frame_errors();
        test_queue_full();
        test_filters_and_limits();
        test_random_traffic();
        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("PASS framed_packet_receiver_queue_core");
        else
            $display("FAIL framed_packet_receiver_queue_core");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL framed_packet_receiver_queue_core");
        $finish;
    end

endmodule
